// ===== rtl/core/sorted_list_insert_remove_macros.svh =====
// Assertion macros for the checker of the sorted list store.
`ifndef SORTED_LIST_INSERT_REMOVE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SLIR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define SLIR_ASSERT(label, prop, msg) \
  `SLIR_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/slir_pkg.sv =====
// Command and status codes of the sorted list store.
package slir_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  localparam int unsigned ValueWidth = 32;

endpackage

// ===== rtl/core/slir_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module slir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sorted_list_insert_remove.sv =====
// Sorted multiset store: ordered insert, first-match remove and in-order dump.
//
// Usage: an item arrives on the input channel (in_valid_i/in_ready_o) with a
// command and a signed 32-bit value. Insert places the value ahead of the
// first stored entry that is not smaller; remove deletes the first equal
// entry; dump returns every entry in ascending order. Results leave on the
// output channel (out_valid_o/out_ready_i), one transfer per result, with
// last_o set on the final result of each item. Command code 3 is accepted
// and produces nothing.
//
// Timing: the entries live in one RAM with a registered read port, and the
// sequencer walks it one entry per cycle, though a dump walk waits while the
// output is stalled. Insert walks down from the top entry to its slot, remove
// walks up to the end of the store, and dump walks every stored entry. A full
// insert, an insert into an empty store, an empty remove or an empty dump
// skips the walk and goes straight to its result. in_ready_o is high only
// while the sequencer is idle.
//
// Reset clears the entry count and the sequencer; the RAM is not cleared,
// since only entries below the count are ever used. A result sits in an
// output register, so the next item is taken while it waits; a stalled
// receiver holds a dump walk until each transfer completes.
module sorted_list_insert_remove import slir_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   command_i,
  input  logic signed [ValueWidth-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [ValueWidth-1:0] entry_value_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_INS      = 6'b000010,
    ST_INS_LAST = 6'b000100,
    ST_RMV      = 6'b001000,
    ST_DUMP     = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_e;

  state_e                      state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic signed [ValueWidth-1:0] val_q, val_d;
  logic [AW-1:0]               rd_idx_q, rd_idx_d;
  logic                        found_q, found_d;
  status_e                     res_status_q, res_status_d;

  logic                        out_valid_q, out_valid_d;
  logic signed [ValueWidth-1:0] out_val_q, out_val_d;
  status_e                     out_status_q, out_status_d;
  logic                        out_last_q, out_last_d;

  // RAM port controls.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic signed [ValueWidth-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic signed [ValueWidth-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic walk_end;
  logic rmv_hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // The output register can take a new result this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  // The entry on the read port is the top stored entry.
  assign walk_end   = ((CW'(rd_idx_q) + CW'(1)) == count_q);
  // Remove has matched at this entry or an earlier one.
  assign rmv_hit    = found_q || (ram_rdata == val_q);

  slir_ram #(
    .WIDTH(ValueWidth),
    .DEPTH(CAPACITY)
  ) u_slir_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    val_d        = val_q;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    res_status_d = res_status_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_val_d    = out_val_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    ram_we    = 1'b0;
    ram_waddr = rd_idx_q;
    ram_wdata = val_q;
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q;

    case (state_q)
      ST_IDLE: begin
        // Insert starts its walk at the top entry, remove and dump at the bottom.
        ram_raddr = (command_i == CMD_INSERT) ? AW'(count_q - CW'(1)) : '0;
        if (in_fire) begin
          ram_re   = 1'b1;
          rd_idx_d = ram_raddr;
          val_d    = value_i;
          found_d  = 1'b0;
          case (command_i)
            CMD_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                res_status_d = STATUS_FULL;
                state_d      = ST_EMIT;
              end else if (count_q == '0) begin
                ram_we       = 1'b1;
                ram_waddr    = '0;
                ram_wdata    = value_i;
                count_d      = count_q + CW'(1);
                res_status_d = STATUS_OK;
                state_d      = ST_EMIT;
              end else begin
                state_d = ST_INS;
              end
            end
            CMD_REMOVE: begin
              if (count_q == '0) begin
                res_status_d = STATUS_NOT_FOUND;
                state_d      = ST_EMIT;
              end else begin
                state_d = ST_RMV;
              end
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                val_d        = '0;
                res_status_d = STATUS_EMPTY;
                state_d      = ST_EMIT;
              end else begin
                state_d = ST_DUMP;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_INS: begin
        if (ram_rdata >= val_q) begin
          // Entry is not smaller: move it up one slot and keep walking down.
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q + AW'(1);
          ram_wdata = ram_rdata;
          if (rd_idx_q == '0) begin
            state_d = ST_INS_LAST;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_idx_q - AW'(1);
            rd_idx_d  = ram_raddr;
          end
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = rd_idx_q + AW'(1);
          ram_wdata    = val_q;
          count_d      = count_q + CW'(1);
          res_status_d = STATUS_OK;
          state_d      = ST_EMIT;
        end
      end

      ST_INS_LAST: begin
        ram_we       = 1'b1;
        ram_waddr    = '0;
        ram_wdata    = val_q;
        count_d      = count_q + CW'(1);
        res_status_d = STATUS_OK;
        state_d      = ST_EMIT;
      end

      ST_RMV: begin
        // After the match, every later entry moves down one slot.
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        found_d = rmv_hit;
        if (walk_end) begin
          if (rmv_hit) begin
            count_d      = count_q - CW'(1);
            res_status_d = STATUS_OK;
          end else begin
            res_status_d = STATUS_NOT_FOUND;
          end
          state_d = ST_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q + AW'(1);
          rd_idx_d  = ram_raddr;
        end
      end

      ST_DUMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_val_d    = ram_rdata;
          out_status_d = STATUS_OK;
          out_last_d   = walk_end;
          if (walk_end) begin
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_idx_q + AW'(1);
            rd_idx_d  = ram_raddr;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_val_d    = val_q;
          out_status_d = res_status_q;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    rd_idx_q     <= rd_idx_d;
    res_status_q <= res_status_d;
    out_val_q    <= out_val_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = out_val_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

endmodule

// ===== rtl/core/slir_checker.sv =====
// Port-level checker for the sorted list store, bound to its top level.
`include "sorted_list_insert_remove_macros.svh"

module slir_checker import slir_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [1:0]                   command_i,
  input logic signed [ValueWidth-1:0] value_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [ValueWidth-1:0] entry_value_o,
  input logic [1:0]                   status_o,
  input logic                         last_o
);

  // A stalled result keeps its contents.
  `SLIR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_value_o) && $stable(status_o) && $stable(last_o), "stalled result changed")

  // Every real command leaves the sequencer busy in the cycle after it is taken.
  `SLIR_ASSERT(a_busy_after_cmd, in_valid_i && in_ready_o && (command_i == CMD_INSERT || command_i == CMD_REMOVE || command_i == CMD_DUMP) |=> !in_ready_o, "sequencer took a command without going busy")

  // Error and empty reports are single results.
  `SLIR_ASSERT(a_err_is_last, out_valid_o && status_o != STATUS_OK |-> last_o, "non-ok status without last")

  // The empty report carries a zero value.
  `SLIR_ASSERT(a_empty_zero, out_valid_o && status_o == STATUS_EMPTY |-> entry_value_o == '0, "empty report with nonzero value")

endmodule

bind sorted_list_insert_remove slir_checker u_slir_checker (.*);
